// ----- rtl/core/assert_macros.svh -----
// Assertion helpers for the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define BLSC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define BLSC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/blsc_pkg.sv -----
package blsc_pkg;

  typedef struct packed {
    logic bus_idle;
    logic motor_running;
    logic brake_request;
    logic lights_request;
  } blsc_in_t;

  typedef struct packed {
    logic [7:0] left_duty;
    logic [7:0] right_duty;
    logic       brake_active;
  } blsc_out_t;

  typedef struct packed {
    logic [15:0] failsafe_period;
    logic [15:0] reminder_interval;
    logic [15:0] reminder_period;
    logic [6:0]  attention_cycles;
    logic [15:0] attention_period;
    logic [15:0] attention_delay;
    logic [7:0]  intensity_low;
    logic [7:0]  intensity_high;
  } blsc_cfg_t;

  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_FAILSAFE_PERIOD   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_REMINDER_INTERVAL = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_REMINDER_PERIOD   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ATTENTION_CYCLES  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_ATTENTION_PERIOD  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_ATTENTION_DELAY   = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_INTENSITY_LOW     = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_INTENSITY_HIGH    = 3'd7;

  localparam blsc_cfg_t CFG_RESET = '{
    failsafe_period:   16'd500,
    reminder_interval: 16'd10000,
    reminder_period:   16'd250,
    attention_cycles:  7'd3,
    attention_period:  16'd100,
    attention_delay:   16'd5000,
    intensity_low:     8'd64,
    intensity_high:    8'd255
  };

endpackage

// ----- rtl/core/blsc_cfg.sv -----
module blsc_cfg
  import blsc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output blsc_cfg_t              cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FAILSAFE_PERIOD:   cfg.failsafe_period   <= cfg_data;
        REG_REMINDER_INTERVAL: cfg.reminder_interval <= cfg_data;
        REG_REMINDER_PERIOD:   cfg.reminder_period   <= cfg_data;
        REG_ATTENTION_CYCLES:  cfg.attention_cycles  <= cfg_data[6:0];
        REG_ATTENTION_PERIOD:  cfg.attention_period  <= cfg_data;
        REG_ATTENTION_DELAY:   cfg.attention_delay   <= cfg_data;
        REG_INTENSITY_LOW:     cfg.intensity_low     <= cfg_data[7:0];
        REG_INTENSITY_HIGH:    cfg.intensity_high    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/core/blsc_step.sv -----
module blsc_step
  import blsc_pkg::*;
#(
  parameter int TIMER_WIDTH = 16,
  parameter int DUTY_FULL   = 255
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      advance,
  input  blsc_in_t  word,
  input  blsc_cfg_t cfg,
  output blsc_out_t result
);

  typedef enum logic [2:0] {
    PH_START, PH_FS_CHECK, PH_FS_DELAY, PH_WAIT, PH_ATT_CHECK, PH_ATT_DELAY, PH_ON_WAIT
  } phase_t;

  localparam int TW = TIMER_WIDTH;
  localparam int LW = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;
  localparam logic [7:0] FULL_LEVEL = 8'((DUTY_FULL > 255) ? 255 : DUTY_FULL);

  function automatic logic [TW-1:0] timer_load(input logic [15:0] v);
    logic [LW-1:0] ext;
    logic [LW-1:0] lim;
    ext = LW'(v);
    lim = LW'((64'd1 << TIMER_WIDTH) - 64'd1);
    timer_load = (ext > lim) ? TW'(lim) : TW'(ext);
  endfunction

  function automatic logic [TW-1:0] delay_load(input logic [15:0] v);
    delay_load = timer_load((v == 16'd0) ? 16'd1 : v);
  endfunction

  phase_t        phase, phase_next;
  logic [TW-1:0] flash_countdown, flash_countdown_next;
  logic [TW-1:0] idle_countdown, idle_countdown_next;
  logic          alternate_flag, alternate_flag_next;
  logic [7:0]    flash_step, flash_step_next;
  logic [7:0]    chosen_intensity, chosen_intensity_next;
  logic          brake_flag, brake_flag_next;
  logic [7:0]    left_level, left_level_next;
  logic [7:0]    right_level, right_level_next;
  logic          done;

  // The phases are visited in the only order one tick can chain them, so a
  // single pass through this block covers every path of the sequence.
  always_comb begin
    phase_next            = phase;
    alternate_flag_next   = alternate_flag;
    flash_step_next       = flash_step;
    chosen_intensity_next = chosen_intensity;
    brake_flag_next       = brake_flag;
    left_level_next       = left_level;
    right_level_next      = right_level;
    done                  = 1'b0;
    flash_countdown_next  = (flash_countdown != '0) ? flash_countdown - 1'b1 : flash_countdown;
    idle_countdown_next   = (idle_countdown != '0) ? idle_countdown - 1'b1 : idle_countdown;

    if (phase_next == PH_START) begin
      brake_flag_next = 1'b0;
      phase_next      = PH_FS_CHECK;
    end

    if (phase_next == PH_FS_DELAY) begin
      if (flash_countdown_next == '0) begin
        phase_next = PH_FS_CHECK;
      end else begin
        done = 1'b1;
      end
    end

    if (!done && phase_next == PH_ATT_DELAY) begin
      if (flash_countdown_next == '0) begin
        flash_step_next = flash_step_next + 8'd1;
        phase_next      = PH_ATT_CHECK;
      end else begin
        done = 1'b1;
      end
    end

    if (!done && phase_next == PH_FS_CHECK) begin
      if (word.bus_idle) begin
        left_level_next      = alternate_flag_next ? FULL_LEVEL : 8'd0;
        right_level_next     = alternate_flag_next ? 8'd0 : FULL_LEVEL;
        alternate_flag_next  = !alternate_flag_next;
        flash_countdown_next = delay_load(cfg.failsafe_period);
        phase_next           = PH_FS_DELAY;
        done                 = 1'b1;
      end else begin
        left_level_next      = 8'd0;
        right_level_next     = 8'd0;
        flash_countdown_next = timer_load(cfg.reminder_interval);
        flash_step_next      = 8'd0;
        phase_next           = PH_WAIT;
      end
    end

    if (!done && phase_next == PH_WAIT) begin
      if (!word.brake_request) begin
        if (word.motor_running) begin
          flash_countdown_next = timer_load(cfg.reminder_interval);
          flash_step_next      = 8'd0;
        end else if (flash_countdown_next == '0) begin
          priority if (flash_step_next == 8'd0) begin
            left_level_next      = FULL_LEVEL;
            right_level_next     = 8'd0;
            flash_step_next      = 8'd1;
            flash_countdown_next = timer_load(cfg.reminder_period);
          end else if (flash_step_next == 8'd1) begin
            left_level_next      = 8'd0;
            right_level_next     = FULL_LEVEL;
            flash_step_next      = 8'd2;
            flash_countdown_next = timer_load(cfg.reminder_period);
          end else begin
            left_level_next      = 8'd0;
            right_level_next     = 8'd0;
            flash_step_next      = 8'd0;
            flash_countdown_next = timer_load(cfg.reminder_interval);
          end
        end
        done = 1'b1;
      end else begin
        chosen_intensity_next = word.lights_request ? cfg.intensity_low : cfg.intensity_high;
        if (idle_countdown_next == '0) begin
          alternate_flag_next = 1'b0;
          flash_step_next     = 8'd0;
          phase_next          = PH_ATT_CHECK;
        end else begin
          left_level_next  = chosen_intensity_next;
          right_level_next = chosen_intensity_next;
          brake_flag_next  = 1'b1;
          phase_next       = PH_ON_WAIT;
        end
      end
    end

    if (!done && phase_next == PH_ATT_CHECK) begin
      if (flash_step_next < {1'b0, cfg.attention_cycles} << 1) begin
        left_level_next      = alternate_flag_next ? chosen_intensity_next : 8'd0;
        right_level_next     = alternate_flag_next ? 8'd0 : chosen_intensity_next;
        alternate_flag_next  = !alternate_flag_next;
        flash_countdown_next = delay_load(cfg.attention_period);
        phase_next           = PH_ATT_DELAY;
        done                 = 1'b1;
      end else begin
        left_level_next  = chosen_intensity_next;
        right_level_next = chosen_intensity_next;
        brake_flag_next  = 1'b1;
        phase_next       = PH_ON_WAIT;
      end
    end

    if (!done && phase_next == PH_ON_WAIT) begin
      if (!word.brake_request) begin
        idle_countdown_next = timer_load(cfg.attention_delay);
        phase_next          = PH_START;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_START;
      flash_countdown  <= '0;
      idle_countdown   <= '0;
      alternate_flag   <= 1'b0;
      flash_step       <= 8'd0;
      chosen_intensity <= 8'd0;
      brake_flag       <= 1'b0;
      left_level       <= 8'd0;
      right_level      <= 8'd0;
    end else if (advance) begin
      phase            <= phase_next;
      flash_countdown  <= flash_countdown_next;
      idle_countdown   <= idle_countdown_next;
      alternate_flag   <= alternate_flag_next;
      flash_step       <= flash_step_next;
      chosen_intensity <= chosen_intensity_next;
      brake_flag       <= brake_flag_next;
      left_level       <= left_level_next;
      right_level      <= right_level_next;
    end
  end

  assign result.left_duty    = left_level_next;
  assign result.right_duty   = right_level_next;
  assign result.brake_active = brake_flag_next;

endmodule

// ----- rtl/core/brake_light_sequencer_core.sv -----
// A word is taken into the input register and passed through the tick logic
// into the output register. Throughput: one word per cycle while the output
// does not stall; a stall on the output holds both registers.
// Reset (synchronous, active high) empties both registers, restarts the sequence
// with the timers expired and loads the default configuration.
module brake_light_sequencer_core
  import blsc_pkg::*;
#(
  parameter int TIMER_WIDTH = 16,
  parameter int DUTY_FULL   = 255
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  blsc_in_t               in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output blsc_out_t              out_data,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  `include "assert_macros.svh"

  blsc_cfg_t cfg;
  blsc_in_t  s1_data;
  logic      s1_valid;
  logic      s1_advance;
  blsc_out_t step_result;

  assign s1_advance = s1_valid && (!out_valid || !out_stall);
  assign in_stall   = s1_valid && !s1_advance;

  blsc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  blsc_step #(
    .TIMER_WIDTH (TIMER_WIDTH),
    .DUTY_FULL   (DUTY_FULL)
  ) u_step (
    .clk     (clk),
    .rst     (rst),
    .advance (s1_advance),
    .word    (s1_data),
    .cfg     (cfg),
    .result  (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        s1_valid <= 1'b1;
      end else if (s1_advance) begin
        s1_valid <= 1'b0;
      end
      if (s1_advance) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data <= in_data;
    end
    if (s1_advance) begin
      out_data <= step_result;
    end
  end

  `BLSC_ASSERT(a_full_pipe_stalls, clk, rst, (s1_valid && out_valid && out_stall) |-> in_stall, "input taken while both stages are held")
  `BLSC_ASSERT(a_out_from_stage, clk, rst, $rose(out_valid) |-> $past(s1_valid), "result appeared without a word in the input stage")
  `BLSC_ASSERT(a_steady_equal, clk, rst, (out_valid && out_data.brake_active) |-> (out_data.left_duty == out_data.right_duty), "steady brake light with unequal lamps")
  `BLSC_ASSERT_ALWAYS(a_reset_empties, clk, rst |=> (!out_valid && !s1_valid), "pipeline not empty after reset")

endmodule
